// ===== rtl/core/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope package
// Phase codes and configuration register indexes shared by the envelope core.
// ----------------------------------------------------------------------------
package adsr_pkg;

  // Envelope phase, as seen on the result channel.
  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ATTACK_STEP   = 2'd0,
    REG_DECAY_STEP    = 2'd1,
    REG_RELEASE_STEP  = 2'd2,
    REG_SUSTAIN_LEVEL = 2'd3
  } reg_idx_e;

endpackage : adsr_pkg

// ===== rtl/core/adsr_in_if.sv =====
// ----------------------------------------------------------------------------
// ADSR gate channel
// Valid/ready channel that carries one gate sample per word.
// ----------------------------------------------------------------------------
interface adsr_in_if;
  logic valid;
  logic ready;
  logic gate;

  modport source (output valid, output gate, input ready);
  modport sink   (input valid, input gate, output ready);
endinterface : adsr_in_if

// ===== rtl/core/adsr_out_if.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope channel
// Valid/ready channel that carries one envelope level and phase per word.
// ----------------------------------------------------------------------------
interface adsr_out_if #(
  parameter int LevelW = 19
);
  logic                     valid;
  logic                     ready;
  logic signed [LevelW-1:0] level;
  logic [2:0]               phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink   (input valid, input level, input phase, output ready);
endinterface : adsr_out_if

// ===== rtl/core/adsr_step.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope step
// Combinational update for one sample: picks the next phase from the old
// phase, old level, gate and gate edge, then adds, subtracts, loads or clears.
// ----------------------------------------------------------------------------
module adsr_step
  import adsr_pkg::*;
#(
  parameter int FracBits = 16
) (
  input  phase_e                             phase_i,
  input  logic signed [FracBits+2:0]         level_i,
  input  logic                               last_gate_i,
  input  logic                               gate_i,
  input  logic [FracBits:0]                  attack_step_i,
  input  logic [FracBits:0]                  decay_step_i,
  input  logic [FracBits:0]                  release_step_i,
  input  logic [FracBits:0]                  sustain_level_i,
  output phase_e                             phase_o,
  output logic signed [FracBits+2:0]         level_o
);

  localparam int unsigned RegW   = FracBits + 1;
  localparam int unsigned LevelW = FracBits + 3;
  localparam int unsigned SumW   = FracBits + 4;

  localparam logic [RegW-1:0] One  = RegW'(1) << FracBits;
  localparam logic [RegW-1:0] Half = RegW'(1) << (FracBits - 1);

  localparam logic signed [SumW-1:0] SumMax = SumW'(2) << FracBits;
  localparam logic signed [SumW-1:0] SumMin = -(SumW'(1) << FracBits);

  logic                      rise;
  logic                      level_pos;
  logic [RegW-1:0]           sus;
  logic signed [LevelW-1:0]  sus_ext;
  logic signed [LevelW-1:0]  one_ext;
  logic signed [LevelW-1:0]  base;
  logic [RegW-1:0]           step;
  logic signed [SumW-1:0]    sum;
  logic signed [SumW-1:0]    sat;
  phase_e                    ph;

  // Sustain above one falls back to one half.
  assign sus     = (sustain_level_i > One) ? Half : sustain_level_i;
  assign sus_ext = $signed({2'b00, sus});
  assign one_ext = $signed({2'b00, One});
  assign rise    = gate_i & ~last_gate_i;

  // The level is strictly positive when the sign bit is clear and it is not zero.
  assign level_pos = ~level_i[LevelW-1] & (level_i != '0);

  // Next phase from the old phase, the old level and the gate.
  always_comb begin
    unique case (phase_i)
      PH_ATTACK: begin
        ph = (level_i <= one_ext) ? PH_ATTACK : PH_DECAY;
        if (!gate_i) ph = PH_RELEASE;
      end
      PH_DECAY: begin
        ph = (level_i > sus_ext) ? PH_DECAY : PH_SUSTAIN;
        if (!gate_i) ph = PH_RELEASE;
      end
      PH_SUSTAIN: ph = gate_i ? PH_SUSTAIN : PH_RELEASE;
      PH_RELEASE: ph = level_pos ? PH_RELEASE : PH_OFF;
      default:    ph = PH_OFF;
    endcase
    base = level_i;
    // A rising gate outside attack restarts attack from zero.
    if (phase_i != PH_ATTACK && rise) begin
      ph   = PH_ATTACK;
      base = '0;
    end
  end

  // Step for the chosen phase; a zero step counts as one.
  always_comb begin
    unique case (ph)
      PH_ATTACK: step = attack_step_i;
      PH_DECAY:  step = decay_step_i;
      default:   step = release_step_i;
    endcase
    if (step == '0) step = One;
  end

  // One add or subtract, then clamp to the range minus one to two.
  always_comb begin
    if (ph == PH_ATTACK) begin
      sum = SumW'(base) + $signed(SumW'(step));
    end else begin
      sum = SumW'(base) - $signed(SumW'(step));
    end
    if (sum > SumMax) begin
      sat = SumMax;
    end else if (sum < SumMin) begin
      sat = SumMin;
    end else begin
      sat = sum;
    end
  end

  // New level by phase.
  always_comb begin
    unique case (ph)
      PH_ATTACK, PH_DECAY, PH_RELEASE: level_o = sat[LevelW-1:0];
      PH_SUSTAIN:                      level_o = sus_ext;
      default:                         level_o = '0;
    endcase
  end

  assign phase_o = ph;

endmodule : adsr_step

// ===== rtl/core/adsr_envelope_generator_core.sv =====
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// Linear attack/decay/sustain/release envelope, one gate sample in and one
// envelope word out per sample, level in signed fixed point.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake     Payload
//  in_if    in   valid/ready   gate (1 bit)
//  out_if   out  valid/ready   level (FracBits+3, signed), phase (3 bits)
//  cfg      in   cfg_we_i      cfg_idx_i (2 bits), cfg_wdata_i (FracBits+1)
//
// One word is accepted per cycle while in_if.ready is high; the result goes
// to the output register, or to the skid register when the output word still
// waits. The update is a single add or subtract and clamp between the envelope
// state registers and the output register. A two-entry output buffer (output
// register plus skid register) lets an input word be taken while a result is
// still waiting; in_if.ready drops only when both entries hold results.
// Reset clears the envelope to off with level zero and loads the register
// defaults; no initialization sweep is needed.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core
  import adsr_pkg::*;
#(
  parameter int FracBits = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  adsr_in_if.sink                in_if,
  adsr_out_if.source             out_if,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [FracBits:0]      cfg_wdata_i
);

  localparam int unsigned RegW   = FracBits + 1;
  localparam int unsigned LevelW = FracBits + 3;

  localparam logic [RegW-1:0] One  = RegW'(1) << FracBits;
  localparam logic [RegW-1:0] Half = RegW'(1) << (FracBits - 1);

  localparam logic signed [LevelW-1:0] LevelMax = LevelW'(2) << FracBits;
  localparam logic signed [LevelW-1:0] LevelMin = -(LevelW'(1) << FracBits);

  // Configuration registers.
  logic [RegW-1:0] attack_step_q;
  logic [RegW-1:0] decay_step_q;
  logic [RegW-1:0] release_step_q;
  logic [RegW-1:0] sustain_level_q;

  // Envelope state.
  phase_e                   phase_q;
  logic signed [LevelW-1:0] level_q;
  logic                     last_gate_q;

  // Output buffer.
  logic                     out_valid_q;
  phase_e                   out_phase_q;
  logic signed [LevelW-1:0] out_level_q;
  logic                     skid_valid_q;
  phase_e                   skid_phase_q;
  logic signed [LevelW-1:0] skid_level_q;

  phase_e                   phase_d;
  logic signed [LevelW-1:0] level_d;
  logic                     in_fire;
  logic                     out_fire;

  assign in_if.ready = ~skid_valid_q;
  assign in_fire     = in_if.valid & ~skid_valid_q;
  assign out_fire    = out_valid_q & out_if.ready;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_step_q   <= One;
      decay_step_q    <= One;
      release_step_q  <= One;
      sustain_level_q <= Half;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ATTACK_STEP:   attack_step_q   <= cfg_wdata_i;
        REG_DECAY_STEP:    decay_step_q    <= cfg_wdata_i;
        REG_RELEASE_STEP:  release_step_q  <= cfg_wdata_i;
        REG_SUSTAIN_LEVEL: sustain_level_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Per-sample update.
  adsr_step #(
    .FracBits (FracBits)
  ) u_step (
    .phase_i         (phase_q),
    .level_i         (level_q),
    .last_gate_i     (last_gate_q),
    .gate_i          (in_if.gate),
    .attack_step_i   (attack_step_q),
    .decay_step_i    (decay_step_q),
    .release_step_i  (release_step_q),
    .sustain_level_i (sustain_level_q),
    .phase_o         (phase_d),
    .level_o         (level_d)
  );

  // Envelope state advances on every accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_OFF;
      level_q     <= '0;
      last_gate_q <= 1'b0;
    end else if (in_fire) begin
      phase_q     <= phase_d;
      level_q     <= level_d;
      last_gate_q <= in_if.gate;
    end
  end

  // Output buffer control: results go to the output register when it is
  // free or draining, otherwise to the skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_fire) skid_valid_q <= 1'b0;
      end else if (in_fire) begin
        if (!out_valid_q || out_fire) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_phase_q <= skid_phase_q;
        out_level_q <= skid_level_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_phase_q <= phase_d;
        out_level_q <= level_d;
      end else begin
        skid_phase_q <= phase_d;
        skid_level_q <= level_d;
      end
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.level = out_level_q;
  assign out_if.phase = out_phase_q;

  // The skid register is only ever filled behind a waiting output word.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  // Off always carries a zero level.
  a_off_level_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OFF) |-> (level_q == '0))
    else $error("envelope off with nonzero level");

  // The level never leaves the clamp range.
  a_level_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q <= LevelMax) && (level_q >= LevelMin))
    else $error("envelope level out of range");

  // A rising gate always lands in attack.
  a_rise_attack : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_if.gate && !last_gate_q) |=> (phase_q == PH_ATTACK))
    else $error("rising gate did not start attack");

endmodule : adsr_envelope_generator_core
